// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros
// shared assertion shorthands, clocked on clk with rst_n as disable
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bha_pkg.sv -----
// ---------------------------------------------------------------------------
// bha_pkg
// request codes, sequencer states and fixed handle constants
// ---------------------------------------------------------------------------
package bha_pkg;

    localparam int HANDLE_W = 9;
    localparam logic [HANDLE_W-1:0] HANDLE_BASE = 9'd10;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_QUERY   = 2'd2,
        REQ_RESERVE = 2'd3
    } req_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_ADDR = 5'b00100,
        ST_MOD  = 5'b01000,
        ST_SCAN = 5'b10000
    } state_t;

endpackage

// ----- rtl/bitmap_handle_allocator_unit.sv -----
// ---------------------------------------------------------------------------
// bitmap_handle_allocator_unit
// first-fit handle allocator over a bitmap held in a synchronous ram
// ---------------------------------------------------------------------------
// Usage: drive req_type and handle_in and raise start; the beat is taken at
// a clock edge where start is high and busy is low. busy stays high until
// the result is presented. The result (result_handle, success, in_use) is
// valid for exactly one cycle while done is high; the receiver cannot stall
// and must take it in that cycle.
// Sequence: free, query and reserve pass from the accepting edge to the
// done cycle through address split, ram read and read-modify-write. Allocate
// reads one bitmap word per cycle from the ram, pipelined with the check of
// the previous word, and scans 1 to NUM_WORDS words; busy is low during the
// done cycle, so a new request can be taken at the edge that ends it.
// Reset: rst_n clears the per-word valid flags, so every word reads as zero
// (all handles free) immediately; the ram itself needs no clearing pass.
// Handles below 10 or past the map are ignored and report success 0.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_handle_allocator_unit #(
    parameter int WORD_WIDTH = 32,
    parameter int NUM_WORDS  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    req_type,
    input  logic [bha_pkg::HANDLE_W-1:0]  handle_in,
    output logic                          done,
    output logic [bha_pkg::HANDLE_W-1:0]  result_handle,
    output logic                          success,
    output logic                          in_use
);
    import bha_pkg::*;

    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BW        = $clog2(WORD_WIDTH);
    localparam int DIV_SHIFT = 16;
    localparam int RW        = DIV_SHIFT + 1;
    localparam int PW        = HANDLE_W + RW;
    localparam int RECIP     = ((1 << DIV_SHIFT) + WORD_WIDTH - 1) / WORD_WIDTH;
    localparam logic [AW-1:0]       LAST_WORD = AW'(NUM_WORDS - 1);
    localparam logic [HANDLE_W-1:0] NW_H      = HANDLE_W'(NUM_WORDS);
    localparam logic [HANDLE_W-1:0] WW_H      = HANDLE_W'(WORD_WIDTH);

    // bitmap ram and per-word valid flags
    logic [WORD_WIDTH-1:0] mem [NUM_WORDS];
    logic [NUM_WORDS-1:0]  valid_reg;
    logic [WORD_WIDTH-1:0] rd_data_reg;
    logic                  rd_valid_reg;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;

    state_t                state_reg, state_next;
    req_t                  req_reg, req_next;
    logic [HANDLE_W-1:0]   handle_reg, handle_next;
    logic [HANDLE_W-1:0]   idx_reg, idx_next;
    logic [HANDLE_W-1:0]   quo_reg, quo_next;
    logic                  low_reg, low_next;
    logic [BW-1:0]         bit_reg, bit_next;
    logic                  hit_reg, hit_next;
    logic [AW-1:0]         scan_word_reg, scan_word_next;
    logic [HANDLE_W-1:0]   base_reg, base_next;

    logic                  done_reg, done_next;
    logic [HANDLE_W-1:0]   result_reg, result_next;
    logic                  success_reg, success_next;
    logic                  in_use_reg, in_use_next;

    logic [WORD_WIDTH-1:0] word_q;
    logic [WORD_WIDTH-1:0] bit_mask;
    logic [BW-1:0]         first_zero;
    logic [PW-1:0]         prod;
    logic [HANDLE_W-1:0]   idx_c;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign word_q   = rd_valid_reg ? rd_data_reg : '0;
    assign bit_mask = {{(WORD_WIDTH-1){1'b0}}, 1'b1} << bit_reg;

    always_comb
    begin
        first_zero = '0;
        for (int i = WORD_WIDTH - 1; i >= 0; i--)
        begin
            if (!word_q[i])
            begin
                first_zero = BW'(i);
            end
        end
    end

    // handle index divided by the word width via reciprocal multiply
    assign idx_c = handle_reg - HANDLE_BASE;
    assign prod  = {{RW{1'b0}}, idx_c} * PW'(RECIP);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        handle_next    = handle_reg;
        idx_next       = idx_reg;
        quo_next       = quo_reg;
        low_next       = low_reg;
        bit_next       = bit_reg;
        hit_next       = hit_reg;
        scan_word_next = scan_word_reg;
        base_next      = base_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        success_next   = success_reg;
        in_use_next    = in_use_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next    = req_t'(req_type);
                    handle_next = handle_in;
                    if (req_t'(req_type) == REQ_ALLOC)
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = '0;
                        scan_word_next = '0;
                        base_next      = HANDLE_BASE;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                low_next   = handle_reg < HANDLE_BASE;
                idx_next   = idx_c;
                quo_next   = prod[DIV_SHIFT +: HANDLE_W];
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                bit_next   = BW'(idx_reg - HANDLE_W'(quo_reg * WW_H));
                hit_next   = !low_reg && (quo_reg < NW_H);
                rd_en      = !low_reg && (quo_reg < NW_H);
                rd_addr    = quo_reg[AW-1:0];
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                done_next    = 1'b1;
                result_next  = '0;
                success_next = 1'b0;
                in_use_next  = 1'b0;
                wr_addr      = quo_reg[AW-1:0];
                unique case (req_reg)
                    REQ_FREE:
                    begin
                        wr_en        = hit_reg;
                        wr_data      = word_q & ~bit_mask;
                        success_next = hit_reg;
                    end
                    REQ_RESERVE:
                    begin
                        wr_en        = hit_reg;
                        wr_data      = word_q | bit_mask;
                        success_next = hit_reg;
                    end
                    REQ_QUERY:
                    begin
                        in_use_next = hit_reg && word_q[bit_reg];
                    end
                    default:
                    begin
                        wr_en = 1'b0;
                    end
                endcase
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (!(&word_q))
                begin
                    wr_en        = 1'b1;
                    wr_addr      = scan_word_reg;
                    wr_data      = word_q | ({{(WORD_WIDTH-1){1'b0}}, 1'b1} << first_zero);
                    done_next    = 1'b1;
                    result_next  = base_reg + {{(HANDLE_W-BW){1'b0}}, first_zero};
                    success_next = 1'b1;
                    in_use_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
                else if (scan_word_reg == LAST_WORD)
                begin
                    done_next    = 1'b1;
                    result_next  = '0;
                    success_next = 1'b0;
                    in_use_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_word_reg + 1'b1;
                    scan_word_next = scan_word_reg + 1'b1;
                    base_next      = base_reg + WW_H;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        handle_reg    <= handle_next;
        idx_reg       <= idx_next;
        quo_reg       <= quo_next;
        low_reg       <= low_next;
        bit_reg       <= bit_next;
        hit_reg       <= hit_next;
        scan_word_reg <= scan_word_next;
        base_reg      <= base_next;
        result_reg    <= result_next;
        success_reg   <= success_next;
        in_use_reg    <= in_use_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign result_handle = result_reg;
    assign success       = success_reg;
    assign in_use        = in_use_reg;

    `AST_NXT(a_start_busy, start && !busy, busy, "accepted beat did not raise busy")
    `AST_IMP(a_done_idle, done, !busy, "result shown while still busy")
    `AST_IMP(a_query_no_ok, done && in_use, !success && (result_handle == '0),
        "query result carries allocate or update fields")
    `AST_IMP(a_wr_range, wr_en, (32'(wr_addr) < NUM_WORDS) && !(rd_en && rd_addr == wr_addr),
        "bitmap write out of range or colliding with read")

endmodule
